>>> hdl/lmts_pkg.sv
package lmts_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;

    localparam logic [8:0]  OAM_DOTS      = 9'd80;
    localparam logic [8:0]  XFER_DOTS     = 9'd172;
    localparam logic [15:0] LINE_DOTS     = 16'd456;
    localparam logic [7:0]  VISIBLE_LINES = 8'd144;
    localparam logic [7:0]  TOTAL_LINES   = 8'd154;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] STAT_RESET = 8'h85;
    localparam logic [7:0] BGP_RESET  = 8'hE4;
    localparam logic [7:0] OBP_RESET  = 8'hFF;
    localparam logic [7:0] UNMAPPED   = 8'hFF;

    // STAT and LCDC bit positions.
    localparam int STAT_HBLANK_IE = 3;
    localparam int STAT_VBLANK_IE = 4;
    localparam int STAT_OAM_IE    = 5;
    localparam int STAT_LYC_IE    = 6;
    localparam int LCDC_ENABLE    = 7;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] reg_address;
        logic [7:0]  dots;
        logic [1:0]  action;
    } item_t;

    typedef struct packed {
        logic [7:0] current_line;
        mode_t      current_mode;
        logic       stat_irq;
        logic       vblank_irq;
        logic [7:0] read_data;
    } result_t;

endpackage

>>> hdl/lcd_mode_timing_and_status_unit.sv
// LCD controller timing and register file.
// The slave channel carries one item per beat: s_tuser selects a dot tick,
// a register write or a register read, and s_tdata carries the dot count,
// the bus address and the write byte. Each beat yields exactly one result
// beat on the master channel with the read byte, the two interrupt flags,
// the mode and the line counter as they stand after the item.
// An accepted beat lands in an input register; once the output register is
// free or being emptied, the mode and line logic updates the display state
// and the result goes into the output register, which drives m_tvalid.
// One item is taken per cycle while m_tready stays high: the state update
// is a single pass through the counters and compares between the input and
// output registers.
// When m_tready is low the output register holds its beat; the input
// register can still take one more beat, and s_tready then drops until the
// result is taken.
// Reset loads the documented register values, puts the display in OAM
// search on line zero with cleared dot counts and empties both registers.
module lcd_mode_timing_and_status_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // dots[7:0], reg_address[23:8], write_data[31:24]
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // read_data[7:0], vblank_irq[8], stat_irq[9],
                                  // current_mode[11:10], current_line[19:12], zero[23:20]
);

    lmts_pkg::item_t   item_reg;
    logic              in_valid_reg;
    lmts_pkg::result_t res;
    lmts_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.action      <= s_tuser;
            item_reg.dots        <= s_tdata[7:0];
            item_reg.reg_address <= s_tdata[23:8];
            item_reg.write_data  <= s_tdata[31:24];
        end
        if (advance)
            out_reg <= res;
    end

    lmts_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (item_reg),
        .res   (res)
    );

endmodule

>>> hdl/lmts_core.sv
module lmts_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  lmts_pkg::item_t  item,
    output lmts_pkg::result_t res
);

    logic [7:0]  control_reg, control_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  scy_reg, scy_next;
    logic [7:0]  scx_reg, scx_next;
    logic [7:0]  line_reg, line_next;
    logic [7:0]  lyc_reg, lyc_next;
    logic [7:0]  bgp_reg, bgp_next;
    logic [7:0]  opal0_reg, opal0_next;
    logic [7:0]  opal1_reg, opal1_next;
    logic [7:0]  wy_reg, wy_next;
    logic [7:0]  wx_reg, wx_next;
    lmts_pkg::mode_t mode_reg, mode_next;
    logic [8:0]  mcnt_reg, mcnt_next;
    logic [15:0] ldc_reg, ldc_next;
    logic        cmp_reg, cmp_next;

    logic [15:0] ldc_sum;
    logic [8:0]  mode_sum;
    logic [7:0]  line_inc;
    logic        line_done;
    logic        eq;

    assign ldc_sum   = ldc_reg + {8'd0, item.dots};
    assign mode_sum  = mcnt_reg + {1'b0, item.dots};
    assign line_inc  = line_reg + 8'd1;
    assign line_done = (ldc_sum >= lmts_pkg::LINE_DOTS);
    assign eq        = (line_next == lyc_reg);

    always_comb
    begin
        control_next = control_reg;
        status_next  = status_reg;
        scy_next     = scy_reg;
        scx_next     = scx_reg;
        line_next    = line_reg;
        lyc_next     = lyc_reg;
        bgp_next     = bgp_reg;
        opal0_next   = opal0_reg;
        opal1_next   = opal1_reg;
        wy_next      = wy_reg;
        wx_next      = wx_reg;
        mode_next    = mode_reg;
        mcnt_next    = mcnt_reg;
        ldc_next     = ldc_reg;
        cmp_next     = cmp_reg;
        res          = '0;

        unique case (item.action)
            lmts_pkg::ACT_TICK:
            begin
                ldc_next = ldc_sum;
                if (line_reg < lmts_pkg::VISIBLE_LINES)
                begin
                    unique case (mode_reg)
                        lmts_pkg::MODE_OAM:
                        begin
                            mcnt_next = mode_sum;
                            if (mode_sum >= lmts_pkg::OAM_DOTS)
                            begin
                                mode_next = lmts_pkg::MODE_XFER;
                                mcnt_next = '0;
                            end
                        end
                        lmts_pkg::MODE_XFER:
                        begin
                            mcnt_next = mode_sum;
                            if (mode_sum >= lmts_pkg::XFER_DOTS)
                            begin
                                mode_next = lmts_pkg::MODE_HBLANK;
                                mcnt_next = '0;
                                // With the display off the line counter drops to zero here.
                                if (!control_reg[lmts_pkg::LCDC_ENABLE])
                                    line_next = '0;
                                if (status_reg[lmts_pkg::STAT_HBLANK_IE])
                                    res.stat_irq = 1'b1;
                            end
                        end
                        lmts_pkg::MODE_HBLANK:
                        begin
                            if (line_done)
                            begin
                                line_next = line_inc;
                                ldc_next  = ldc_sum - lmts_pkg::LINE_DOTS;
                                mcnt_next = '0;
                                if (line_inc == lmts_pkg::VISIBLE_LINES)
                                begin
                                    mode_next      = lmts_pkg::MODE_VBLANK;
                                    res.vblank_irq = 1'b1;
                                    if (status_reg[lmts_pkg::STAT_VBLANK_IE])
                                        res.stat_irq = 1'b1;
                                end
                                else
                                begin
                                    mode_next = lmts_pkg::MODE_OAM;
                                    if (status_reg[lmts_pkg::STAT_OAM_IE])
                                        res.stat_irq = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // VBlank mode on a visible line falls back to OAM search.
                            mode_next = lmts_pkg::MODE_OAM;
                            mcnt_next = '0;
                        end
                    endcase
                end
                else
                begin
                    mode_next = lmts_pkg::MODE_VBLANK;
                    if (line_done)
                    begin
                        ldc_next  = ldc_sum - lmts_pkg::LINE_DOTS;
                        mcnt_next = '0;
                        line_next = line_inc;
                        if (line_inc >= lmts_pkg::TOTAL_LINES)
                        begin
                            line_next = '0;
                            mode_next = lmts_pkg::MODE_OAM;
                            if (status_reg[lmts_pkg::STAT_OAM_IE])
                                res.stat_irq = 1'b1;
                        end
                    end
                    else
                    begin
                        mcnt_next = ldc_sum[8:0];
                    end
                end
                status_next = {status_reg[7:3], eq, mode_next};
                if (eq && !cmp_reg && status_reg[lmts_pkg::STAT_LYC_IE])
                    res.stat_irq = 1'b1;
                cmp_next = eq;
            end
            lmts_pkg::ACT_WRITE:
            begin
                unique case (item.reg_address)
                    lmts_pkg::ADDR_LCDC: control_next = item.write_data;
                    lmts_pkg::ADDR_STAT: status_next  = {item.write_data[7:3], status_reg[2:0]};
                    lmts_pkg::ADDR_SCY:  scy_next     = item.write_data;
                    lmts_pkg::ADDR_SCX:  scx_next     = item.write_data;
                    lmts_pkg::ADDR_LYC:  lyc_next     = item.write_data;
                    lmts_pkg::ADDR_BGP:  bgp_next     = item.write_data;
                    lmts_pkg::ADDR_OBP0: opal0_next   = item.write_data;
                    lmts_pkg::ADDR_OBP1: opal1_next   = item.write_data;
                    lmts_pkg::ADDR_WY:   wy_next      = item.write_data;
                    lmts_pkg::ADDR_WX:   wx_next      = item.write_data;
                    default: ;
                endcase
            end
            lmts_pkg::ACT_READ:
            begin
                unique case (item.reg_address)
                    lmts_pkg::ADDR_LCDC: res.read_data = control_reg;
                    lmts_pkg::ADDR_STAT: res.read_data = status_reg;
                    lmts_pkg::ADDR_SCY:  res.read_data = scy_reg;
                    lmts_pkg::ADDR_SCX:  res.read_data = scx_reg;
                    lmts_pkg::ADDR_LY:   res.read_data = line_reg;
                    lmts_pkg::ADDR_LYC:  res.read_data = lyc_reg;
                    lmts_pkg::ADDR_BGP:  res.read_data = bgp_reg;
                    lmts_pkg::ADDR_OBP0: res.read_data = opal0_reg;
                    lmts_pkg::ADDR_OBP1: res.read_data = opal1_reg;
                    lmts_pkg::ADDR_WY:   res.read_data = wy_reg;
                    lmts_pkg::ADDR_WX:   res.read_data = wx_reg;
                    default:             res.read_data = lmts_pkg::UNMAPPED;
                endcase
            end
            default: ;
        endcase

        res.current_mode = mode_next;
        res.current_line = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= lmts_pkg::LCDC_RESET;
            status_reg  <= lmts_pkg::STAT_RESET;
            scy_reg     <= '0;
            scx_reg     <= '0;
            line_reg    <= '0;
            lyc_reg     <= '0;
            bgp_reg     <= lmts_pkg::BGP_RESET;
            opal0_reg   <= lmts_pkg::OBP_RESET;
            opal1_reg   <= lmts_pkg::OBP_RESET;
            wy_reg      <= '0;
            wx_reg      <= '0;
            mode_reg    <= lmts_pkg::MODE_OAM;
            mcnt_reg    <= '0;
            ldc_reg     <= '0;
            cmp_reg     <= 1'b0;
        end
        else if (en)
        begin
            control_reg <= control_next;
            status_reg  <= status_next;
            scy_reg     <= scy_next;
            scx_reg     <= scx_next;
            line_reg    <= line_next;
            lyc_reg     <= lyc_next;
            bgp_reg     <= bgp_next;
            opal0_reg   <= opal0_next;
            opal1_reg   <= opal1_next;
            wy_reg      <= wy_next;
            wx_reg      <= wx_next;
            mode_reg    <= mode_next;
            mcnt_reg    <= mcnt_next;
            ldc_reg     <= ldc_next;
            cmp_reg     <= cmp_next;
        end
    end

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < lmts_pkg::TOTAL_LINES)
        else $error("line counter out of range");

    a_vblank_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg >= lmts_pkg::VISIBLE_LINES) |-> (mode_reg == lmts_pkg::MODE_VBLANK))
        else $error("blanking line outside VBlank mode");

    a_vblank_irq_line: assert property (@(posedge clk) disable iff (!rst_n)
        (en && res.vblank_irq) |=> (line_reg == lmts_pkg::VISIBLE_LINES))
        else $error("VBlank interrupt without entering the first blanking line");

    a_oam_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == lmts_pkg::MODE_OAM) |-> (mcnt_reg < lmts_pkg::OAM_DOTS))
        else $error("OAM search dot count overran");

    a_xfer_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == lmts_pkg::MODE_XFER) |-> (mcnt_reg < lmts_pkg::XFER_DOTS))
        else $error("transfer dot count overran");

endmodule

>>> tb/sv/lcd_status_checker.sv
module lcd_status_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // dots[7:0], reg_address[23:8], write_data[31:24]
    input  logic [1:0]  s_tuser,  // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,  // read_data[7:0], vblank_irq[8], stat_irq[9],
                                  // current_mode[11:10], current_line[19:12]
    output int          mismatches,
    output int          backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  lcdc;
    logic [7:0]  status_byte;
    logic [7:0]  scy;
    logic [7:0]  scx;
    logic [7:0]  ly;
    logic [7:0]  lyc;
    logic [7:0]  bgp;
    logic [7:0]  obp0;
    logic [7:0]  obp1;
    logic [7:0]  wy;
    logic [7:0]  wx;
    lmts_pkg::mode_t disp_mode;
    logic [8:0]  mode_dots;
    logic [15:0] line_dots;
    logic        lyc_match_seen;

    lmts_pkg::result_t pending_status[$];
    int          error_count = 0;

    assign mismatches = error_count;

    // Advances the display state by one item and returns the status beat it produces.
    function automatic lmts_pkg::result_t apply_lcd_item(input lmts_pkg::item_t it);
        lmts_pkg::result_t res;
        logic              eq;
        res = '0;
        case (it.action)
            lmts_pkg::ACT_TICK:
            begin
                line_dots = line_dots + it.dots;
                if (ly < lmts_pkg::VISIBLE_LINES)
                begin
                    case (disp_mode)
                        lmts_pkg::MODE_OAM:
                        begin
                            mode_dots = mode_dots + it.dots;
                            if (mode_dots >= lmts_pkg::OAM_DOTS)
                            begin
                                disp_mode = lmts_pkg::MODE_XFER;
                                mode_dots = '0;
                            end
                        end
                        lmts_pkg::MODE_XFER:
                        begin
                            mode_dots = mode_dots + it.dots;
                            if (mode_dots >= lmts_pkg::XFER_DOTS)
                            begin
                                disp_mode = lmts_pkg::MODE_HBLANK;
                                mode_dots = '0;
                                // A disabled display drops back to the top line here.
                                if (!lcdc[lmts_pkg::LCDC_ENABLE])
                                    ly = '0;
                                if (status_byte[lmts_pkg::STAT_HBLANK_IE])
                                    res.stat_irq = 1'b1;
                            end
                        end
                        lmts_pkg::MODE_HBLANK:
                        begin
                            if (line_dots >= lmts_pkg::LINE_DOTS)
                            begin
                                ly        = ly + 8'd1;
                                line_dots = line_dots - lmts_pkg::LINE_DOTS;
                                mode_dots = '0;
                                if (ly == lmts_pkg::VISIBLE_LINES)
                                begin
                                    disp_mode      = lmts_pkg::MODE_VBLANK;
                                    res.vblank_irq = 1'b1;
                                    if (status_byte[lmts_pkg::STAT_VBLANK_IE])
                                        res.stat_irq = 1'b1;
                                end
                                else
                                begin
                                    disp_mode = lmts_pkg::MODE_OAM;
                                    if (status_byte[lmts_pkg::STAT_OAM_IE])
                                        res.stat_irq = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            disp_mode = lmts_pkg::MODE_OAM;
                            mode_dots = '0;
                        end
                    endcase
                end
                else
                begin
                    disp_mode = lmts_pkg::MODE_VBLANK;
                    if (line_dots >= lmts_pkg::LINE_DOTS)
                    begin
                        line_dots = line_dots - lmts_pkg::LINE_DOTS;
                        mode_dots = '0;
                        ly        = ly + 8'd1;
                        if (ly >= lmts_pkg::TOTAL_LINES)
                        begin
                            ly        = '0;
                            disp_mode = lmts_pkg::MODE_OAM;
                            if (status_byte[lmts_pkg::STAT_OAM_IE])
                                res.stat_irq = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_dots = line_dots[8:0];
                    end
                end
                eq          = (ly == lyc);
                status_byte = {status_byte[7:3], eq, disp_mode};
                if (eq && !lyc_match_seen && status_byte[lmts_pkg::STAT_LYC_IE])
                    res.stat_irq = 1'b1;
                lyc_match_seen = eq;
            end
            lmts_pkg::ACT_WRITE:
            begin
                case (it.reg_address)
                    lmts_pkg::ADDR_LCDC: lcdc        = it.write_data;
                    lmts_pkg::ADDR_STAT: status_byte = {it.write_data[7:3], status_byte[2:0]};
                    lmts_pkg::ADDR_SCY:  scy         = it.write_data;
                    lmts_pkg::ADDR_SCX:  scx         = it.write_data;
                    lmts_pkg::ADDR_LYC:  lyc         = it.write_data;
                    lmts_pkg::ADDR_BGP:  bgp         = it.write_data;
                    lmts_pkg::ADDR_OBP0: obp0        = it.write_data;
                    lmts_pkg::ADDR_OBP1: obp1        = it.write_data;
                    lmts_pkg::ADDR_WY:   wy          = it.write_data;
                    lmts_pkg::ADDR_WX:   wx          = it.write_data;
                    default:   ;
                endcase
            end
            lmts_pkg::ACT_READ:
            begin
                case (it.reg_address)
                    lmts_pkg::ADDR_LCDC: res.read_data = lcdc;
                    lmts_pkg::ADDR_STAT: res.read_data = status_byte;
                    lmts_pkg::ADDR_SCY:  res.read_data = scy;
                    lmts_pkg::ADDR_SCX:  res.read_data = scx;
                    lmts_pkg::ADDR_LY:   res.read_data = ly;
                    lmts_pkg::ADDR_LYC:  res.read_data = lyc;
                    lmts_pkg::ADDR_BGP:  res.read_data = bgp;
                    lmts_pkg::ADDR_OBP0: res.read_data = obp0;
                    lmts_pkg::ADDR_OBP1: res.read_data = obp1;
                    lmts_pkg::ADDR_WY:   res.read_data = wy;
                    lmts_pkg::ADDR_WX:   res.read_data = wx;
                    default:             res.read_data = lmts_pkg::UNMAPPED;
                endcase
            end
            default: ;
        endcase
        res.current_mode = disp_mode;
        res.current_line = ly;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        lmts_pkg::item_t   beat_in;
        lmts_pkg::result_t want;
        lmts_pkg::result_t got;
        if (!rst_n)
        begin
            lcdc           = lmts_pkg::LCDC_RESET;
            status_byte    = lmts_pkg::STAT_RESET;
            scy            = '0;
            scx            = '0;
            ly             = '0;
            lyc            = '0;
            bgp            = lmts_pkg::BGP_RESET;
            obp0           = lmts_pkg::OBP_RESET;
            obp1           = lmts_pkg::OBP_RESET;
            wy             = '0;
            wx             = '0;
            disp_mode      = lmts_pkg::MODE_OAM;
            mode_dots      = '0;
            line_dots      = '0;
            lyc_match_seen = 1'b0;
            pending_status.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                beat_in.action      = s_tuser;
                beat_in.dots        = s_tdata[7:0];
                beat_in.reg_address = s_tdata[23:8];
                beat_in.write_data  = s_tdata[31:24];
                pending_status.push_back(apply_lcd_item(beat_in));
            end
            if (m_tvalid && m_tready)
            begin
                got = lmts_pkg::result_t'(m_tdata[19:0]);
                if (pending_status.size() == 0)
                begin
                    $error("status beat arrived with no item outstanding");
                    error_count++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("vblank_irq", want.vblank_irq, got.vblank_irq);
                    check_field("stat_irq", want.stat_irq, got.stat_irq);
                    check_field("current_mode", want.current_mode, got.current_mode);
                    check_field("current_line", want.current_line, got.current_line);
                end
            end
        end
        backlog = pending_status.size();
    end

endmodule

>>> tb/sv/tb_lcd_mode_timing_and_status_unit.sv
module tb_lcd_mode_timing_and_status_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE       = 2'd3;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         BEATS_PER_PASS = 515;
    localparam int         DRAIN_CYCLES   = 16;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = lmts_pkg::ACT_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int mismatches;
    int backlog;
    int cycles    = 0;
    int src_idle  = 34;
    int sink_idle = 88;

    lcd_mode_timing_and_status_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lcd_status_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_beat(input lmts_pkg::item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {it.write_data, it.reg_address, it.dots};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic issue(input logic [1:0] action, input logic [7:0] dots,
                         input logic [15:0] addr, input logic [7:0] data);
        lmts_pkg::item_t it;
        it.action      = action;
        it.dots        = dots;
        it.reg_address = addr;
        it.write_data  = data;
        push_beat(it);
    endtask

    // Mostly long ticks so that whole frames go by, with register traffic
    // aimed at the decoded window and an occasional stray address or action.
    function automatic lmts_pkg::item_t random_item();
        lmts_pkg::item_t it;
        int              pick;
        it.dots        = 8'($urandom);
        it.reg_address = 16'($urandom);
        it.write_data  = 8'($urandom);
        pick           = $urandom_range(99);
        if (pick < 62)
        begin
            it.action = lmts_pkg::ACT_TICK;
            if ($urandom_range(9) < 7)
                it.dots = 8'($urandom_range(255, 140));
        end
        else if (pick < 97)
        begin
            it.action = (pick < 80) ? lmts_pkg::ACT_WRITE : lmts_pkg::ACT_READ;
            if ($urandom_range(99) < 85)
                it.reg_address = 16'(lmts_pkg::ADDR_LCDC + $urandom_range(11));
            if (it.action == lmts_pkg::ACT_WRITE && it.reg_address == lmts_pkg::ADDR_LCDC
                && $urandom_range(19) != 0)
                it.write_data[lmts_pkg::LCDC_ENABLE] = 1'b1;
            if (it.action == lmts_pkg::ACT_WRITE && it.reg_address == lmts_pkg::ADDR_LYC
                && $urandom_range(9) < 7)
                it.write_data = 8'($urandom_range(153));
        end
        else
        begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // STAT still holds its reset value before the first tick.
        issue(lmts_pkg::ACT_READ,  8'h00, lmts_pkg::ADDR_STAT, 8'h00);
        issue(lmts_pkg::ACT_READ,  8'h00, lmts_pkg::ADDR_LCDC, 8'h00);
        issue(lmts_pkg::ACT_READ,  8'h00, 16'hFF46,            8'h00);
        issue(lmts_pkg::ACT_READ,  8'h00, 16'h0000,            8'h00);
        issue(lmts_pkg::ACT_READ,  8'hFF, 16'hFFFF,            8'hFF);
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_STAT, 8'hFF);
        issue(lmts_pkg::ACT_READ,  8'h00, lmts_pkg::ADDR_STAT, 8'h00);
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_LY,   8'h55);
        issue(lmts_pkg::ACT_WRITE, 8'h00, 16'hFF46,            8'hAA);
        issue(lmts_pkg::ACT_WRITE, 8'h00, 16'h0000,            8'h12);
        issue(ACT_NONE,            8'hFF, lmts_pkg::ADDR_LCDC, 8'h00);
        issue(lmts_pkg::ACT_TICK,  8'h00, 16'h0000,            8'h00);
        issue(lmts_pkg::ACT_TICK,  8'hFF, 16'h0000,            8'h00);
        // Display switched off while the transfer is still running.
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_LCDC, 8'h11);
        issue(lmts_pkg::ACT_TICK,  8'hFF, 16'h0000,            8'h00);
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_LCDC, lmts_pkg::LCDC_RESET);
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_LYC,  8'd1);
        issue(lmts_pkg::ACT_TICK,  8'hFF, 16'hFFFF,            8'hFF);
        issue(lmts_pkg::ACT_TICK,  8'hFF, 16'hFFFF,            8'hFF);
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_SCY,  8'hFF);
        issue(lmts_pkg::ACT_READ,  8'h00, lmts_pkg::ADDR_SCY,  8'h00);
        issue(lmts_pkg::ACT_READ,  8'h00, lmts_pkg::ADDR_LY,   8'h00);
        issue(lmts_pkg::ACT_WRITE, 8'h00, lmts_pkg::ADDR_LYC,  8'd153);
        issue(lmts_pkg::ACT_READ,  8'h00, lmts_pkg::ADDR_WX,   8'h00);
        wait_for_results();

        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    src_idle  = 34;
                    sink_idle = 88;
                end
                1:
                begin
                    src_idle  = 88;
                    sink_idle = 34;
                end
                default:
                begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase
            repeat (BEATS_PER_PASS) push_beat(random_item());
            // Hold the source off until every outstanding status beat is back.
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hdl/lmts_pkg.sv
hdl/lmts_core.sv
hdl/lcd_mode_timing_and_status_unit.sv
tb/sv/lcd_status_checker.sv
tb/sv/tb_lcd_mode_timing_and_status_unit.sv
